// ----- rtl/axs_pkg.sv -----
// Shared types, opcode masks and decode helpers for the ARM64 reference scanner.
// Used by every module under rtl; depends on nothing.
package axs_pkg;

  localparam logic [31:0] NOP_WORD   = 32'hd503201f;
  localparam logic [31:0] ADR_MASK   = 32'h1f000000;
  localparam logic [31:0] ADR_OP     = 32'h10000000;
  localparam logic [31:0] ADD_MASK   = 32'hff8003e0;
  localparam logic [31:0] ADD_OP     = 32'h91000000;
  localparam logic [31:0] BR_MASK    = 32'hfffffc1f;
  localparam logic [31:0] BR_OP      = 32'hd61f0000;
  localparam logic [31:0] MOVZ_MASK  = 32'hff800000;
  localparam logic [31:0] MOVZ_OP    = 32'hd2800000;
  localparam logic [31:0] ADDR_MASK  = 32'hffc00000;
  localparam logic [31:0] ADDR_OP    = 32'h8b000000;
  localparam logic [31:0] LDST_MASK  = 32'h3e0003e0;
  localparam logic [31:0] LDST_OP    = 32'h38000000;
  localparam logic [31:0] LIT_MASK   = 32'hbf000000;
  localparam logic [31:0] LIT_OP     = 32'h18000000;
  localparam logic [31:0] LITSW_MASK = 32'hff000000;
  localparam logic [31:0] LITSW_OP   = 32'h98000000;
  localparam logic [31:0] B_MASK     = 32'h7c000000;
  localparam logic [31:0] B_OP       = 32'h14000000;
  localparam logic [31:0] BC_MASK    = 32'hff000010;
  localparam logic [31:0] BC_OP      = 32'h54000000;
  localparam logic [31:0] CB_MASK    = 32'h7e000000;
  localparam logic [31:0] CB_OP      = 32'h34000000;
  localparam logic [31:0] TB_OP      = 32'h36000000;

  localparam logic [3:0] PK_ADR       = 4'd0;
  localparam logic [3:0] PK_ADD       = 4'd1;
  localparam logic [3:0] PK_ADD_ADD   = 4'd2;
  localparam logic [3:0] PK_LDST      = 4'd3;
  localparam logic [3:0] PK_ADD_LDST  = 4'd4;
  localparam logic [3:0] PK_LITERAL   = 4'd5;
  localparam logic [3:0] PK_B         = 4'd6;
  localparam logic [3:0] PK_BL        = 4'd7;
  localparam logic [3:0] PK_BCOND     = 4'd8;
  localparam logic [3:0] PK_CBZ       = 4'd9;
  localparam logic [3:0] PK_TBZ       = 4'd10;
  localparam logic [3:0] PK_STUB_BR   = 4'd11;
  localparam logic [3:0] PK_STUB_ADD  = 4'd12;
  localparam logic [3:0] PK_STUB_MOVZ = 4'd13;

  localparam logic [1:0] RK_DATA = 2'd0;
  localparam logic [1:0] RK_CODE = 2'd1;
  localparam logic [1:0] RK_CALL = 2'd2;

  localparam logic [1:0] CFG_REGISTER_ALL = 2'd0;
  localparam logic [1:0] CFG_SEARCH_ADDR  = 2'd1;

  typedef struct packed {
    logic [31:0] word;
    logic [63:0] addr;
    logic        last;
  } insn_t;

  typedef struct packed {
    logic [63:0] site_addr;
    logic [63:0] ref_addr;
    logic [3:0]  pattern_kind;
    logic [1:0]  ref_kind;
    logic [31:0] last_word;
    logic        final_result;
  } rec_t;

  typedef struct packed {
    logic [1:0] num;
    rec_t       r0;
    rec_t       r1;
  } push_t;

  function automatic logic is_br(logic [31:0] w, logic [4:0] r);
    return ((w & BR_MASK) == BR_OP) && (w[9:5] == r);
  endfunction

  function automatic logic is_add(logic [31:0] w, logic [4:0] rn);
    return (w & ADD_MASK) == (ADD_OP | {22'b0, rn, 5'b0});
  endfunction

  function automatic logic [23:0] add_off(logic [31:0] w);
    return w[22] ? {w[21:10], 12'b0} : {12'b0, w[21:10]};
  endfunction

  function automatic logic ldst_hit(logic [31:0] w, logic [4:0] rn, logic [63:0] base,
                                    logic [63:0] s);
    logic [1:0]  sz;
    logic [1:0]  opc;
    logic        ok;
    logic [63:0] uoff;
    logic [63:0] soff;
    sz   = w[31:30];
    opc  = w[23:22];
    ok   = (opc < 2'd2) || (opc == 2'd2 && sz < 2'd3) || (opc == 2'd3 && sz < 2'd2);
    uoff = {52'b0, w[21:10]} << sz;
    soff = {{55{w[20]}}, w[20:12]};
    if (((w & LDST_MASK) != (LDST_OP | {22'b0, rn, 5'b0})) || !ok) return 1'b0;
    if (w[24]) return (base + uoff) == s;
    if (w[21] || w[10]) return 1'b0;
    return (base + soff) == s;
  endfunction

endpackage

// ----- rtl/axs_if.sv -----
// Valid/ready channel interfaces: instruction beats, record beats, config writes.
// Depends on nothing.
interface axs_insn_if;
  logic        valid;
  logic        ready;
  logic [31:0] insn_word;
  logic [63:0] insn_addr;
  logic        region_end;
  modport source (output valid, insn_word, insn_addr, region_end, input ready);
  modport sink (input valid, insn_word, insn_addr, region_end, output ready);
endinterface

interface axs_rec_if;
  logic        valid;
  logic        ready;
  logic [63:0] site_addr;
  logic [63:0] ref_addr;
  logic [3:0]  pattern_kind;
  logic [1:0]  ref_kind;
  logic [31:0] last_word;
  logic        final_result;
  modport source (output valid, site_addr, ref_addr, pattern_kind, ref_kind, last_word,
                  final_result, input ready);
  modport sink (input valid, site_addr, ref_addr, pattern_kind, ref_kind, last_word,
                final_result, output ready);
endinterface

interface axs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/axs_core.sv -----
// Input register, pending-pattern state and single-pass decode of one word.
// Depends on axs_pkg.
module axs_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  axs_pkg::insn_t    in_item_i,
  input  logic              register_all_i,
  input  logic [63:0]       search_addr_i,
  input  logic [1:0]        free_i,
  output logic              push_o,
  output axs_pkg::push_t    push_data_o
);

  localparam logic [2:0] STUB_IDLE  = 3'd0;
  localparam logic [2:0] STUB_FIRST = 3'd1;
  localparam logic [2:0] STUB_ADD   = 3'd2;
  localparam logic [2:0] STUB_MOVZ  = 3'd3;
  localparam logic [2:0] STUB_SHIFT = 3'd4;
  localparam logic [2:0] DATA_IDLE  = 3'd0;
  localparam logic [2:0] DATA_FIRST = 3'd1;
  localparam logic [2:0] DATA_ADD   = 3'd2;
  localparam logic [2:0] DATA_ADR   = 3'd3;

  logic           ir_v_q;
  axs_pkg::insn_t ir_q;
  logic [2:0]     stub_q, stub_d, data_q, data_d;
  logic [63:0]    site_q, site_d, base_q, base_d, movz_val_q, movz_val_d, tgt_q, tgt_d;
  logic [4:0]     first_q, first_d, second_q, second_d, movz_reg_q, movz_reg_d;
  logic [23:0]    off_q, off_d;
  logic [31:0]    word_a_q, word_a_d, word_b_q, word_b_d;

  logic           fire;
  logic           c0v, c1v, c2v;
  axs_pkg::rec_t  c0, c1, c2, r0, r1;
  logic [1:0]     num;

  always_comb begin
    logic [31:0] w;
    logic [63:0] a, s, t, off;
    logic        rg, done;
    w = ir_q.word;
    a = ir_q.addr;
    s = search_addr_i;
    rg = register_all_i;
    t = '0;
    off = '0;
    done = 1'b0;
    stub_d = stub_q; data_d = data_q; site_d = site_q; base_d = base_q;
    first_d = first_q; second_d = second_q; off_d = off_q; movz_reg_d = movz_reg_q;
    movz_val_d = movz_val_q; tgt_d = tgt_q; word_a_d = word_a_q; word_b_d = word_b_q;
    c0v = 1'b0; c1v = 1'b0; c2v = 1'b0;
    c0 = '0; c1 = '0; c2 = '0;

    if (w != axs_pkg::NOP_WORD && stub_q != STUB_IDLE) begin
      unique case (stub_q)
        STUB_FIRST: begin
          priority if (axs_pkg::is_br(w, first_q)) begin
            if (rg || base_q == s) begin
              c0v = 1'b1;
              c0 = '{a, base_q, axs_pkg::PK_STUB_BR, axs_pkg::RK_CODE, w, 1'b0};
              done = 1'b1;
            end
          end else if (axs_pkg::is_add(w, first_q)) begin
            second_d = w[4:0];
            off_d = axs_pkg::add_off(w);
            tgt_d = base_q + {40'b0, axs_pkg::add_off(w)};
            word_b_d = w;
            stub_d = STUB_ADD;
            data_d = DATA_ADD;
            done = 1'b1;
          end else if ((w & axs_pkg::MOVZ_MASK) == axs_pkg::MOVZ_OP) begin
            movz_reg_d = w[4:0];
            movz_val_d = {48'b0, w[20:5]} << {w[22:21], 4'b0};
            stub_d = STUB_MOVZ;
            data_d = DATA_ADR;
            done = 1'b1;
          end else begin
          end
        end
        STUB_ADD, STUB_SHIFT: begin
          if (axs_pkg::is_br(w, second_q) && (rg || tgt_q == s)) begin
            c0v = 1'b1;
            c0 = '{a, tgt_q, (stub_q == STUB_ADD) ? axs_pkg::PK_STUB_ADD
                                                  : axs_pkg::PK_STUB_MOVZ,
                   axs_pkg::RK_CODE, w, 1'b0};
            done = 1'b1;
          end
        end
        STUB_MOVZ: begin
          if ((w & axs_pkg::ADDR_MASK) == axs_pkg::ADDR_OP && w[9:5] == first_q &&
              w[20:16] == movz_reg_q) begin
            second_d = w[4:0];
            tgt_d = base_q + (movz_val_q << w[15:10]);
            stub_d = STUB_SHIFT;
            done = 1'b1;
          end
        end
        default: done = 1'b0;
      endcase
      if (!done && !rg) begin
        t = base_q + {40'b0, off_q};
        priority if (base_q == s) begin
          c0v = 1'b1;
          c0 = '{site_q, base_q, axs_pkg::PK_ADR, axs_pkg::RK_DATA, word_a_q, 1'b0};
        end else if (data_q == DATA_FIRST) begin
          c0v = axs_pkg::ldst_hit(w, first_q, base_q, s);
          c0 = '{site_q, s, axs_pkg::PK_LDST, axs_pkg::RK_DATA, w, 1'b0};
        end else if (data_q == DATA_ADD) begin
          priority if (t == s) begin
            c0v = 1'b1;
            c0 = '{site_q, s, axs_pkg::PK_ADD, axs_pkg::RK_DATA, word_b_q, 1'b0};
          end else if (axs_pkg::is_add(w, second_q)) begin
            c0v = (t + {40'b0, axs_pkg::add_off(w)}) == s;
            c0 = '{site_q, s, axs_pkg::PK_ADD_ADD, axs_pkg::RK_DATA, w, 1'b0};
          end else begin
            c0v = axs_pkg::ldst_hit(w, second_q, t, s);
            c0 = '{site_q, s, axs_pkg::PK_ADD_LDST, axs_pkg::RK_DATA, w, 1'b0};
          end
        end else begin
        end
      end
      if (!done || c0v) begin
        stub_d = STUB_IDLE;
        data_d = DATA_IDLE;
      end
    end

    if (w != axs_pkg::NOP_WORD) begin
      priority if ((w & axs_pkg::ADR_MASK) == axs_pkg::ADR_OP) begin
        off = {{43{w[23]}}, w[23:5], w[30:29]};
        t = w[31] ? ({a[63:12], 12'b0} + {off[51:0], 12'b0}) : (a + off);
        c1v = rg;
        c1 = '{a, t, axs_pkg::PK_ADR, axs_pkg::RK_DATA, w, 1'b0};
        stub_d = STUB_FIRST;
        data_d = DATA_FIRST;
        site_d = a;
        base_d = t;
        first_d = w[4:0];
        word_a_d = w;
        off_d = '0;
      end else if ((w & axs_pkg::LIT_MASK) == axs_pkg::LIT_OP ||
                   (w & axs_pkg::LITSW_MASK) == axs_pkg::LITSW_OP) begin
        t = a + {{43{w[23]}}, w[23:5], 2'b0};
        c1v = rg || t == s;
        c1 = '{a, t, axs_pkg::PK_LITERAL, axs_pkg::RK_DATA, w, 1'b0};
      end else if ((w & axs_pkg::B_MASK) == axs_pkg::B_OP) begin
        t = a + {{36{w[25]}}, w[25:0], 2'b0};
        c1v = rg || t == s;
        c1 = '{a, t, w[31] ? axs_pkg::PK_BL : axs_pkg::PK_B,
               w[31] ? axs_pkg::RK_CALL : axs_pkg::RK_CODE, w, 1'b0};
      end else if ((w & axs_pkg::BC_MASK) == axs_pkg::BC_OP) begin
        t = a + {{43{w[23]}}, w[23:5], 2'b0};
        c1v = rg || t == s;
        c1 = '{a, t, axs_pkg::PK_BCOND, axs_pkg::RK_CODE, w, 1'b0};
      end else if ((w & axs_pkg::CB_MASK) == axs_pkg::CB_OP) begin
        t = a + {{43{w[23]}}, w[23:5], 2'b0};
        c1v = rg || t == s;
        c1 = '{a, t, axs_pkg::PK_CBZ, axs_pkg::RK_CODE, w, 1'b0};
      end else if ((w & axs_pkg::CB_MASK) == axs_pkg::TB_OP) begin
        t = a + {{48{w[18]}}, w[18:5], 2'b0};
        c1v = rg || t == s;
        c1 = '{a, t, axs_pkg::PK_TBZ, axs_pkg::RK_CODE, w, 1'b0};
      end else begin
      end
    end

    if (ir_q.last && stub_d != STUB_IDLE) begin
      if (!rg) begin
        priority if (base_d == s) begin
          c2v = 1'b1;
          c2 = '{site_d, base_d, axs_pkg::PK_ADR, axs_pkg::RK_DATA, word_a_d, 1'b0};
        end else if (data_d == DATA_ADD && (base_d + {40'b0, off_d}) == s) begin
          c2v = 1'b1;
          c2 = '{site_d, s, axs_pkg::PK_ADD, axs_pkg::RK_DATA, word_b_d, 1'b0};
        end else begin
        end
      end
      stub_d = STUB_IDLE;
      data_d = DATA_IDLE;
    end
  end

  always_comb begin
    r0 = c0v ? c0 : (c1v ? c1 : c2);
    r1 = (c0v && c1v) ? c1 : c2;
    num = (c0v && c1v && c2v) ? 2'd2 : (2'({1'b0, c0v}) + 2'({1'b0, c1v}) + 2'({1'b0, c2v}));
    r0.final_result = (num == 2'd1);
    r1.final_result = 1'b1;
  end

  assign fire        = ir_v_q && (free_i >= num);
  assign in_ready_o  = !ir_v_q || fire;
  assign push_o      = fire;
  assign push_data_o = '{num, r0, r1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ir_v_q <= 1'b0;
      stub_q <= STUB_IDLE;
      data_q <= DATA_IDLE;
      site_q <= '0; base_q <= '0; first_q <= '0; second_q <= '0; off_q <= '0;
      movz_reg_q <= '0; movz_val_q <= '0; tgt_q <= '0; word_a_q <= '0; word_b_q <= '0;
    end else begin
      if (in_ready_o) ir_v_q <= in_valid_i;
      if (fire) begin
        stub_q <= stub_d; data_q <= data_d; site_q <= site_d; base_q <= base_d;
        first_q <= first_d; second_q <= second_d; off_q <= off_d;
        movz_reg_q <= movz_reg_d; movz_val_q <= movz_val_d; tgt_q <= tgt_d;
        word_a_q <= word_a_d; word_b_q <= word_b_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) ir_q <= in_item_i;
  end

endmodule

// ----- rtl/axs_outq.sv -----
// Two-entry record queue between the decode stage and the record channel.
// Depends on axs_pkg.
module axs_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  axs_pkg::push_t push_data_i,
  output logic [1:0]     free_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output axs_pkg::rec_t  out_rec_o
);

  axs_pkg::rec_t ent_q [2];
  logic [1:0]    cnt_q, cnt_d;
  logic          head_q;
  logic          tail;
  logic          pop;
  logic [1:0]    add_n;

  assign free_o      = 2'd2 - cnt_q;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_rec_o   = ent_q[head_q];
  assign pop         = out_valid_o && out_ready_i;
  assign tail        = head_q ^ cnt_q[0];
  assign add_n       = push_i ? push_data_i.num : 2'd0;
  assign cnt_d       = cnt_q + add_n - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      head_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (pop) head_q <= ~head_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (add_n != 2'd0) ent_q[tail] <= push_data_i.r0;
    if (add_n == 2'd2) ent_q[~tail] <= push_data_i.r1;
  end

endmodule

// ----- rtl/arm64_xref_scanner_unit.sv -----
// Top level of the ARM64 PC-relative reference scanner.
// Depends on axs_pkg, axs_if, axs_core and axs_outq.
//
//  port    dir   beat
//  insn_i  in    insn_word, insn_addr, region_end
//  rec_o   out   site_addr, ref_addr, pattern_kind, ref_kind, last_word, final_result
//  cfg_i   in    index (0 register_all, 1 search_addr), data
//
// One word per cycle while the queue has room: a word is registered, decoded against the pending state
// in the next cycle and its 0 to 2 records land in a two-entry queue.
// A word with two records waits until the queue is empty, one with a single record while it is full.
// A word is held in the input register and its records in queue entries before they reach rec_o.
// Reset clears pending state, the queue and both config registers.
// cfg_i is always ready.
module arm64_xref_scanner_unit (
  input  logic     clk_i,
  input  logic     rst_ni,
  axs_insn_if.sink insn_i,
  axs_rec_if.source rec_o,
  axs_cfg_if.sink  cfg_i
);

  logic           register_all_q;
  logic [63:0]    search_addr_q;
  logic [1:0]     free;
  logic           push;
  axs_pkg::push_t push_data;
  axs_pkg::insn_t item;
  axs_pkg::rec_t  rec;

  assign cfg_i.ready = 1'b1;
  assign item = '{insn_i.insn_word, insn_i.insn_addr, insn_i.region_end};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      register_all_q <= 1'b0;
      search_addr_q  <= '0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == axs_pkg::CFG_REGISTER_ALL) register_all_q <= cfg_i.data[0];
      if (cfg_i.index == axs_pkg::CFG_SEARCH_ADDR) search_addr_q <= cfg_i.data;
    end
  end

  axs_core u_core (
    .clk_i,
    .rst_ni,
    .in_valid_i     (insn_i.valid),
    .in_ready_o     (insn_i.ready),
    .in_item_i      (item),
    .register_all_i (register_all_q),
    .search_addr_i  (search_addr_q),
    .free_i         (free),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  axs_outq u_outq (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .free_o      (free),
    .out_valid_o (rec_o.valid),
    .out_ready_i (rec_o.ready),
    .out_rec_o   (rec)
  );

  assign rec_o.site_addr    = rec.site_addr;
  assign rec_o.ref_addr     = rec.ref_addr;
  assign rec_o.pattern_kind = rec.pattern_kind;
  assign rec_o.ref_kind     = rec.ref_kind;
  assign rec_o.last_word    = rec.last_word;
  assign rec_o.final_result = rec.final_result;

endmodule

// ----- rtl/axs_checker.sv -----
// Port-level checks on the record channel of the scanner, bound to the top level.
// Depends on axs_pkg and arm64_xref_scanner_unit.
module axs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid,
  input logic        ready,
  input logic [63:0] site_addr,
  input logic [63:0] ref_addr,
  input logic [3:0]  pattern_kind,
  input logic [1:0]  ref_kind,
  input logic [31:0] last_word,
  input logic        final_result
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid && !ready |=> valid && $stable(site_addr) && $stable(ref_addr) &&
    $stable(pattern_kind) && $stable(last_word) && $stable(final_result))
    else $error("record changed while stalled");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid |-> pattern_kind <= axs_pkg::PK_STUB_MOVZ)
    else $error("pattern kind out of range");

  a_ref_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid |-> ((pattern_kind <= axs_pkg::PK_LITERAL) == (ref_kind == axs_pkg::RK_DATA)) &&
              ((pattern_kind == axs_pkg::PK_BL) == (ref_kind == axs_pkg::RK_CALL)))
    else $error("ref kind does not fit pattern kind");

  a_link_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid && (pattern_kind == axs_pkg::PK_B || pattern_kind == axs_pkg::PK_BL) |->
    last_word[31] == (pattern_kind == axs_pkg::PK_BL))
    else $error("b/bl kind does not match link bit");

endmodule

bind arm64_xref_scanner_unit axs_checker u_axs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .valid        (rec_o.valid),
  .ready        (rec_o.ready),
  .site_addr    (rec_o.site_addr),
  .ref_addr     (rec_o.ref_addr),
  .pattern_kind (rec_o.pattern_kind),
  .ref_kind     (rec_o.ref_kind),
  .last_word    (rec_o.last_word),
  .final_result (rec_o.final_result)
);

// ----- tb/sv/arm64_xref_scanner_unit_checker.sv -----
// Checker for the ARM64 reference scanner: watches the word, record and config
// channels, predicts the records of every accepted word and compares them in order.
// Depends on axs_pkg and axs_if.
`timescale 1ns / 1ps
module arm64_xref_scanner_unit_checker
  import axs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  axs_insn_if  insn_i,
  axs_rec_if   rec_o,
  axs_cfg_if   cfg_i,
  output int   fail_count_o,
  output int   pending_o,
  output logic beat_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_FIRST, ST_AFTER_ADD, ST_AFTER_MOVZ, ST_AFTER_SHADD
  } stub_st_e;
  typedef enum logic [2:0] {D_IDLE, D_FIRST, D_AFTER_ADD, D_ADR_ONLY} data_st_e;

  logic        all_mode;
  logic [63:0] target_q;
  stub_st_e    stub_st;
  data_st_e    data_st;
  logic [63:0] p_site, p_base, p_stub_tgt, p_movz_val;
  logic [4:0]  p_reg1, p_reg2, p_movz_reg;
  logic [23:0] p_off;
  logic [31:0] p_word_a, p_word_b;
  rec_t        want_q[$];
  rec_t        step_recs[$];

  assign pending_o = want_q.size();
  assign beat_o = (insn_i.valid && insn_i.ready) || (rec_o.valid && rec_o.ready);

  function automatic logic [63:0] sx(logic [63:0] v, int bits);
    logic [63:0] m;
    m = 64'd1 << (bits - 1);
    v = v & ((m << 1) - 1);
    return (v ^ m) - m;
  endfunction

  function automatic logic br_of(logic [31:0] w, logic [4:0] r);
    return (w & BR_MASK) == BR_OP && w[9:5] == r;
  endfunction

  function automatic logic addi_of(logic [31:0] w, logic [4:0] rn);
    return (w & ADD_MASK) == (ADD_OP | {22'b0, rn, 5'b0});
  endfunction

  function automatic logic [23:0] addi_imm(logic [31:0] w);
    return w[22] ? {w[21:10], 12'b0} : {12'b0, w[21:10]};
  endfunction

  function automatic logic mem_hits(logic [31:0] w, logic [4:0] rn, logic [63:0] base,
                                    logic [63:0] s);
    logic [1:0] sz;
    logic [1:0] opc;
    sz = w[31:30];
    opc = w[23:22];
    if ((w & LDST_MASK) != (LDST_OP | {22'b0, rn, 5'b0})) return 1'b0;
    if (!(opc < 2 || (opc == 2 && sz < 3) || (opc == 3 && sz < 2))) return 1'b0;
    if (w[24]) return base + ({52'b0, w[21:10]} << sz) == s;
    if (w[21] || w[10]) return 1'b0;
    return base + sx({55'b0, w[20:12]}, 9) == s;
  endfunction

  task automatic add_rec(logic [63:0] site, logic [63:0] refa, logic [3:0] pk,
                         logic [1:0] rk, logic [31:0] lw);
    rec_t r;
    if (step_recs.size() >= 2) return;
    r = '{site_addr: site, ref_addr: refa, pattern_kind: pk, ref_kind: rk,
          last_word: lw, final_result: 1'b0};
    step_recs.push_back(r);
  endtask

  task automatic drop_pending();
    stub_st = ST_IDLE;
    data_st = D_IDLE;
  endtask

  task automatic follow_pending(logic [31:0] w, logic [63:0] a);
    logic [63:0] s;
    logic [63:0] t;
    s = target_q;
    case (stub_st)
      ST_FIRST: begin
        if (br_of(w, p_reg1)) begin
          if (all_mode || p_base == s) begin
            add_rec(a, p_base, PK_STUB_BR, RK_CODE, w);
            drop_pending();
            return;
          end
        end else if (addi_of(w, p_reg1)) begin
          p_reg2 = w[4:0];
          p_off = addi_imm(w);
          p_stub_tgt = p_base + {40'b0, p_off};
          p_word_b = w;
          stub_st = ST_AFTER_ADD;
          data_st = D_AFTER_ADD;
          return;
        end else if ((w & MOVZ_MASK) == MOVZ_OP) begin
          p_movz_reg = w[4:0];
          p_movz_val = {48'b0, w[20:5]} << (w[22:21] * 16);
          stub_st = ST_AFTER_MOVZ;
          data_st = D_ADR_ONLY;
          return;
        end
      end
      ST_AFTER_ADD: begin
        if (br_of(w, p_reg2) && (all_mode || p_stub_tgt == s)) begin
          add_rec(a, p_stub_tgt, PK_STUB_ADD, RK_CODE, w);
          drop_pending();
          return;
        end
      end
      ST_AFTER_MOVZ: begin
        if ((w & ADDR_MASK) == ADDR_OP && w[9:5] == p_reg1 && w[20:16] == p_movz_reg) begin
          p_reg2 = w[4:0];
          p_stub_tgt = p_base + (p_movz_val << w[15:10]);
          stub_st = ST_AFTER_SHADD;
          return;
        end
      end
      ST_AFTER_SHADD: begin
        if (br_of(w, p_reg2) && (all_mode || p_stub_tgt == s)) begin
          add_rec(a, p_stub_tgt, PK_STUB_MOVZ, RK_CODE, w);
          drop_pending();
          return;
        end
      end
      default: begin
        drop_pending();
        return;
      end
    endcase
    if (!all_mode) begin
      t = p_base + {40'b0, p_off};
      if (p_base == s) add_rec(p_site, p_base, PK_ADR, RK_DATA, p_word_a);
      else if (data_st == D_FIRST) begin
        if (mem_hits(w, p_reg1, p_base, s)) add_rec(p_site, s, PK_LDST, RK_DATA, w);
      end else if (data_st == D_AFTER_ADD) begin
        if (t == s) add_rec(p_site, s, PK_ADD, RK_DATA, p_word_b);
        else if (addi_of(w, p_reg2)) begin
          if (t + {40'b0, addi_imm(w)} == s) add_rec(p_site, s, PK_ADD_ADD, RK_DATA, w);
        end else if (mem_hits(w, p_reg2, t, s)) add_rec(p_site, s, PK_ADD_LDST, RK_DATA, w);
      end
    end
    drop_pending();
  endtask

  task automatic decode_word(logic [31:0] w, logic [63:0] a);
    logic [63:0] t;
    logic [63:0] off;
    logic        hit;
    if ((w & ADR_MASK) == ADR_OP) begin
      off = sx({43'b0, w[23:5], w[30:29]}, 21);
      if (w[31]) t = (a & ~64'hfff) + (off << 12);
      else t = a + off;
      if (all_mode) add_rec(a, t, PK_ADR, RK_DATA, w);
      stub_st = ST_FIRST;
      data_st = D_FIRST;
      p_site = a;
      p_base = t;
      p_reg1 = w[4:0];
      p_word_a = w;
      p_off = '0;
      return;
    end
    if ((w & LIT_MASK) == LIT_OP || (w & LITSW_MASK) == LITSW_OP) begin
      t = a + sx({43'b0, w[23:5], 2'b0}, 21);
      if (all_mode || t == target_q) add_rec(a, t, PK_LITERAL, RK_DATA, w);
    end else if ((w & B_MASK) == B_OP) begin
      t = a + sx({36'b0, w[25:0], 2'b0}, 28);
      if (all_mode || t == target_q) begin
        if (w[31]) add_rec(a, t, PK_BL, RK_CALL, w);
        else add_rec(a, t, PK_B, RK_CODE, w);
      end
    end else if ((w & BC_MASK) == BC_OP) begin
      t = a + sx({43'b0, w[23:5], 2'b0}, 21);
      if (all_mode || t == target_q) add_rec(a, t, PK_BCOND, RK_CODE, w);
    end else if ((w & CB_MASK) == CB_OP) begin
      t = a + sx({43'b0, w[23:5], 2'b0}, 21);
      if (all_mode || t == target_q) add_rec(a, t, PK_CBZ, RK_CODE, w);
    end else if ((w & CB_MASK) == TB_OP) begin
      t = a + sx({48'b0, w[18:5], 2'b0}, 16);
      if (all_mode || t == target_q) add_rec(a, t, PK_TBZ, RK_CODE, w);
    end
  endtask

  task automatic close_region();
    if (stub_st != ST_IDLE && !all_mode) begin
      if (p_base == target_q) add_rec(p_site, p_base, PK_ADR, RK_DATA, p_word_a);
      else if (data_st == D_AFTER_ADD && p_base + {40'b0, p_off} == target_q)
        add_rec(p_site, target_q, PK_ADD, RK_DATA, p_word_b);
    end
    drop_pending();
  endtask

  task automatic predict(logic [31:0] w, logic [63:0] a, logic last);
    step_recs.delete();
    if (w != NOP_WORD) begin
      if (stub_st != ST_IDLE) follow_pending(w, a);
      decode_word(w, a);
    end
    if (last && stub_st != ST_IDLE) close_region();
    if (step_recs.size() > 0) step_recs[step_recs.size() - 1].final_result = 1'b1;
    foreach (step_recs[i]) want_q.push_back(step_recs[i]);
  endtask

  task automatic compare(rec_t got);
    rec_t w;
    if (want_q.size() == 0) begin
      $error("record with nothing expected: site %h ref %h", got.site_addr, got.ref_addr);
      fail_count_o++;
      return;
    end
    w = want_q.pop_front();
    if (got.site_addr !== w.site_addr) begin
      $error("site_addr expected %h actual %h", w.site_addr, got.site_addr);
      fail_count_o++;
    end
    if (got.ref_addr !== w.ref_addr) begin
      $error("ref_addr expected %h actual %h", w.ref_addr, got.ref_addr);
      fail_count_o++;
    end
    if (got.pattern_kind !== w.pattern_kind) begin
      $error("pattern_kind expected %0d actual %0d", w.pattern_kind, got.pattern_kind);
      fail_count_o++;
    end
    if (got.ref_kind !== w.ref_kind) begin
      $error("ref_kind expected %0d actual %0d", w.ref_kind, got.ref_kind);
      fail_count_o++;
    end
    if (got.last_word !== w.last_word) begin
      $error("last_word expected %h actual %h", w.last_word, got.last_word);
      fail_count_o++;
    end
    if (got.final_result !== w.final_result) begin
      $error("final_result expected %0d actual %0d", w.final_result, got.final_result);
      fail_count_o++;
    end
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      all_mode = 1'b0;
      target_q = '0;
      drop_pending();
      p_site = '0; p_base = '0; p_stub_tgt = '0; p_movz_val = '0;
      p_reg1 = '0; p_reg2 = '0; p_movz_reg = '0; p_off = '0;
      p_word_a = '0; p_word_b = '0;
      want_q.delete();
    end else begin
      if (rec_o.valid && rec_o.ready)
        compare('{site_addr: rec_o.site_addr, ref_addr: rec_o.ref_addr,
                  pattern_kind: rec_o.pattern_kind, ref_kind: rec_o.ref_kind,
                  last_word: rec_o.last_word, final_result: rec_o.final_result});
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == CFG_REGISTER_ALL) all_mode = cfg_i.data[0];
        else if (cfg_i.index == CFG_SEARCH_ADDR) target_q = cfg_i.data;
      end
      if (insn_i.valid && insn_i.ready)
        predict(insn_i.insn_word, insn_i.insn_addr, insn_i.region_end);
    end
  end

endmodule

// ----- tb/sv/arm64_xref_scanner_unit_test.sv -----
// Testbench top for the ARM64 reference scanner: clock, reset, word and config
// stimulus, record sink with stalls, watchdog and verdict.
// Depends on axs_pkg, axs_if, arm64_xref_scanner_unit and its checker.
`timescale 1ns / 1ps
module arm64_xref_scanner_unit_test;
  import axs_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  logic beat;
  logic calm;
  logic hold_sink;
  int   idle_cycles;
  logic [63:0] cur_pc;
  logic [63:0] goal;

  axs_insn_if insn_i ();
  axs_rec_if  rec_o ();
  axs_cfg_if  cfg_i ();

  arm64_xref_scanner_unit DUT (.clk_i(clk_i), .rst_ni(rst_ni), .insn_i(insn_i),
                               .rec_o(rec_o), .cfg_i(cfg_i));

  arm64_xref_scanner_unit_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .insn_i(insn_i), .rec_o(rec_o), .cfg_i(cfg_i),
    .fail_count_o(fail_count), .pending_o(pending), .beat_o(beat));

  always #4 clk_i = ~clk_i;

  initial begin
    insn_i.valid = 1'b0;
    insn_i.insn_word = '0;
    insn_i.insn_addr = '0;
    insn_i.region_end = 1'b0;
    rec_o.ready = 1'b0;
    cfg_i.valid = 1'b0;
    cfg_i.index = CFG_REGISTER_ALL;
    cfg_i.data = '0;
    calm = 1'b0;
    hold_sink = 1'b0;
  end

  always @(posedge clk_i) begin
    if (hold_sink) rec_o.ready <= 1'b0;
    else rec_o.ready <= calm ? 1'b1 : ($urandom_range(99) >= 9);
  end

  always @(posedge clk_i) begin
    if (beat || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send(logic [31:0] w, logic [63:0] a, logic last);
    if (!calm)
      while ($urandom_range(99) < 9) begin
        insn_i.valid <= 1'b0;
        @(posedge clk_i);
      end
    insn_i.valid <= 1'b1;
    insn_i.insn_word <= w;
    insn_i.insn_addr <= a;
    insn_i.region_end <= last;
    @(posedge clk_i);
    while (!insn_i.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    insn_i.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [63:0] d);
    cfg_i.valid <= 1'b1;
    cfg_i.index <= idx;
    cfg_i.data <= d;
    @(posedge clk_i);
    while (!cfg_i.ready) @(posedge clk_i);
    cfg_i.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [31:0] adr_to(logic [63:0] pc, logic [63:0] t, logic [4:0] rd,
                                         logic page);
    logic [63:0] d;
    if (page) d = ((t & ~64'hfff) - (pc & ~64'hfff)) >> 12;
    else d = t - pc;
    return {page, d[1:0], 5'b10000, d[20:2], rd};
  endfunction

  function automatic logic [31:0] pick_word(logic [4:0] r1, logic [4:0] r2);
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(11))
      0: w = {1'b1, w[30:29], 5'b10000, w[23:5], r1};
      1: w = (w & ~ADD_MASK) | ADD_OP | {22'b0, r1, 5'b0} | (w & 32'h00400000);
      2: w = {22'h3587c0, r2, 5'b0};
      3: w = (w & ~MOVZ_MASK) | MOVZ_OP;
      4: w = (w & ~ADDR_MASK) | ADDR_OP | {11'b0, w[20:16], w[15:10], r1, w[4:0]};
      5: w = (w & ~LDST_MASK) | LDST_OP | {22'b0, r1, 5'b0};
      6: w = (w & ~LDST_MASK) | LDST_OP | {22'b0, r2, 5'b0};
      7: w = NOP_WORD;
      8: w = (w & ~B_MASK) | B_OP;
      9: w = (w & ~BC_MASK) | BC_OP;
      10: w = (w & ~CB_MASK) | (w[25] ? TB_OP : CB_OP);
      default: ;
    endcase
    return w;
  endfunction

  task automatic run_random(int n);
    logic [4:0]  r1;
    logic [4:0]  r2;
    logic [31:0] w;
    for (int i = 0; i < n; i++) begin
      r1 = 5'($urandom());
      r2 = 5'($urandom());
      if ($urandom_range(3) != 0) begin
        send(adr_to(cur_pc, goal, r1, 1'($urandom())), cur_pc, 1'b0);
        cur_pc += 4;
        if ($urandom_range(3) == 0) begin
          send(NOP_WORD, cur_pc, 1'b0);
          cur_pc += 4;
        end
        case ($urandom_range(3))
          0: w = {10'h244, 12'h0, r1, r2};
          1: w = {9'h1a5, 2'b00, 16'h1, r2} ;
          default: w = pick_word(r1, r2);
        endcase
        send(w, cur_pc, 1'b0);
        cur_pc += 4;
        if (w[31:23] == 9'h1a5) begin
          send({11'h458, r2, 6'd0, r1, r1}, cur_pc, 1'b0);
          cur_pc += 4;
          r2 = r1;
        end
        send($urandom_range(1) ? {22'h3587c0, r2, 5'b0} : pick_word(r2, r2), cur_pc,
             $urandom_range(7) == 0);
      end else begin
        send(pick_word(r1, r2), $urandom_range(9) == 0 ? rnd64() : cur_pc,
             $urandom_range(7) == 0);
      end
      cur_pc += 4;
      if ($urandom_range(40) == 0) cur_pc = rnd64() & ~64'h3;
    end
  endtask

  initial begin
    cur_pc = 64'h4000;
    goal = 64'h4000;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_cfg(CFG_REGISTER_ALL, 64'd1);
    send(32'h10000000, 64'h0, 1'b0);
    send(32'hf0ffffff, 64'hffff_ffff_ffff_fffc, 1'b0);
    send(32'h91000400, 64'h4, 1'b0);
    send(32'hd61f0000, 64'h8, 1'b0);
    send(32'h14000000, 64'hc, 1'b0);
    send(32'h97ffffff, 64'h10, 1'b0);
    send(32'h54ffffe0, 64'h14, 1'b0);
    send(32'hb5ffffe0, 64'h18, 1'b0);
    send(32'h37ffffe0, 64'h1c, 1'b0);
    send(32'h98000020, 64'h20, 1'b0);
    send(32'h10000001, 64'h24, 1'b0);
    send(32'hd2e00022, 64'h28, 1'b0);
    send(32'h8b223023, 64'h2c, 1'b0);
    send(NOP_WORD, 64'h30, 1'b0);
    send(32'hd61f0060, 64'h34, 1'b1);
    send(32'hffffffff, 64'hffff_ffff_ffff_ffff, 1'b1);
    drain();
    write_cfg(CFG_REGISTER_ALL, 64'd0);
    write_cfg(CFG_SEARCH_ADDR, 64'h1004);
    send(32'h10008000, 64'h0, 1'b0);
    send(32'h91001000, 64'h4, 1'b0);
    send(32'hf9400000, 64'h8, 1'b1);
    send(32'h10008001, 64'h10, 1'b0);
    send(32'hb9400821, 64'h14, 1'b1);
    send(32'h10008000, 64'h20, 1'b1);
    drain();
    calm = 1'b1;
    hold_sink = 1'b1;
    write_cfg(CFG_REGISTER_ALL, 64'd1);
    fork
      run_random(40);
      begin
        repeat (150) @(posedge clk_i);
        hold_sink = 1'b0;
      end
    join
    calm = 1'b0;
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      goal = (ph == 5) ? 64'hffff_ffff_ffff_fffc : (ph == 4 ? 64'h0 : rnd64() & ~64'h3);
      cur_pc = goal - 64'd8000 + 64'($urandom_range(4000)) * 64'd4;
      write_cfg(CFG_REGISTER_ALL, 64'(ph % 2));
      write_cfg(CFG_SEARCH_ADDR, goal);
      run_random(55);
      drain();
    end
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
